// ===== rtl/frrs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frrs_pkg
// Shared widths, constants and pipeline sideband types for the Fresnel
// reflect/refract selector.
// ----------------------------------------------------------------------------
package frrs_pkg;

    localparam int COS_W       = 16;
    localparam int ETA_W       = 14;
    localparam int SAMPLE_W    = 16;
    localparam int KR_W        = 17;
    localparam int ROOT_ITER   = 16;
    localparam int ROOT_W      = 2 * ROOT_ITER;
    localparam int PROD_W      = 30;
    localparam int SINT_QB     = 15;
    localparam int SUM_W       = 31;
    localparam int RATIO_NW    = SUM_W + 16;
    localparam int RATIO_QB    = 17;

    localparam logic [ETA_W-1:0]  ETA_T_RESET = 14'd6144;
    localparam logic [31:0]       ONE_Q30     = 32'h4000_0000;
    localparam logic [KR_W-1:0]   ONE_Q16     = 17'h1_0000;

    typedef struct packed {
        logic                exiting;
        logic [SAMPLE_W-1:0] sample;
        logic [ETA_W-1:0]    eta_i;
        logic [COS_W-1:0]    c;
    } front_side_t;

    typedef struct packed {
        logic                exiting;
        logic                tir;
        logic [SAMPLE_W-1:0] sample;
        logic [ETA_W-1:0]    eta_i;
        logic [COS_W-1:0]    c;
    } mid_side_t;

    typedef struct packed {
        logic                exiting;
        logic                tir;
        logic                den_zero;
        logic [SAMPLE_W-1:0] sample;
    } tail_side_t;

endpackage
`default_nettype wire

// ===== rtl/frrs_sqrt_pipe.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frrs_sqrt_pipe
// Pipelined integer square root, one result bit per register stage, with a
// sideband word and valid bit carried alongside.
// ----------------------------------------------------------------------------
module frrs_sqrt_pipe #(
    parameter int ITER = 16,
    parameter int SW   = 1
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire logic [2*ITER-1:0] in_val,
    input  wire logic [SW-1:0]     in_side,
    output logic                   out_valid,
    output logic [ITER-1:0]        out_root,
    output logic [SW-1:0]          out_side
);

    localparam int W = 2 * ITER;

    logic [W-1:0]  rem_reg  [0:ITER-1];
    logic [W-1:0]  res_reg  [0:ITER-1];
    logic [SW-1:0] side_reg [0:ITER-1];
    logic          vld_reg  [0:ITER-1];

    for (genvar k = 0; k < ITER; k++) begin : g_stage
        localparam logic [W-1:0] BIT = W'(1) << (2 * (ITER - 1 - k));
        logic [W-1:0]  rem_in;
        logic [W-1:0]  res_in;
        logic [SW-1:0] side_in;
        logic          vld_in;
        logic [W-1:0]  trial;
        logic [W-1:0]  rem_next;
        logic [W-1:0]  res_next;

        if (k == 0) begin : g_first
            assign rem_in  = in_val;
            assign res_in  = '0;
            assign side_in = in_side;
            assign vld_in  = in_valid;
        end else begin : g_rest
            assign rem_in  = rem_reg[k-1];
            assign res_in  = res_reg[k-1];
            assign side_in = side_reg[k-1];
            assign vld_in  = vld_reg[k-1];
        end

        always_comb begin
            trial = res_in + BIT;
            if (rem_in >= trial) begin
                rem_next = rem_in - trial;
                res_next = (res_in >> 1) + BIT;
            end else begin
                rem_next = rem_in;
                res_next = res_in >> 1;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= vld_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k]  <= rem_next;
                res_reg[k]  <= res_next;
                side_reg[k] <= side_in;
            end
        end
    end

    assign out_valid = vld_reg[ITER-1];
    assign out_root  = res_reg[ITER-1][ITER-1:0];
    assign out_side  = side_reg[ITER-1];

endmodule
`default_nettype wire

// ===== rtl/frrs_div_pipe.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frrs_div_pipe
// Pipelined restoring divider, one quotient bit per register stage. The
// caller guarantees that the quotient fits in QB bits.
// ----------------------------------------------------------------------------
module frrs_div_pipe #(
    parameter int NW = 30,
    parameter int DW = 14,
    parameter int QB = 15,
    parameter int SW = 1
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          en,
    input  wire logic          in_valid,
    input  wire logic [NW-1:0] in_num,
    input  wire logic [DW-1:0] in_den,
    input  wire logic [SW-1:0] in_side,
    output logic               out_valid,
    output logic [QB-1:0]      out_quot,
    output logic [SW-1:0]      out_side
);

    localparam int W = (NW > DW + QB) ? NW : DW + QB;

    logic [NW-1:0] rem_reg  [0:QB-1];
    logic [DW-1:0] den_reg  [0:QB-1];
    logic [QB-1:0] quot_reg [0:QB-1];
    logic [SW-1:0] side_reg [0:QB-1];
    logic          vld_reg  [0:QB-1];

    for (genvar k = 0; k < QB; k++) begin : g_stage
        localparam int J = QB - 1 - k;
        logic [NW-1:0] rem_in;
        logic [DW-1:0] den_in;
        logic [QB-1:0] quot_in;
        logic [SW-1:0] side_in;
        logic          vld_in;
        logic [W-1:0]  trial;
        logic          ge;
        logic [NW-1:0] rem_next;
        logic [QB-1:0] quot_next;

        if (k == 0) begin : g_first
            assign rem_in  = in_num;
            assign den_in  = in_den;
            assign quot_in = '0;
            assign side_in = in_side;
            assign vld_in  = in_valid;
        end else begin : g_rest
            assign rem_in  = rem_reg[k-1];
            assign den_in  = den_reg[k-1];
            assign quot_in = quot_reg[k-1];
            assign side_in = side_reg[k-1];
            assign vld_in  = vld_reg[k-1];
        end

        always_comb begin
            trial     = W'(den_in) << J;
            ge        = W'(rem_in) >= trial;
            rem_next  = ge ? NW'(W'(rem_in) - trial) : rem_in;
            quot_next = quot_in | (QB'(ge) << J);
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= vld_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k]  <= rem_next;
                den_reg[k]  <= den_in;
                quot_reg[k] <= quot_next;
                side_reg[k] <= side_in;
            end
        end
    end

    assign out_valid = vld_reg[QB-1];
    assign out_quot  = quot_reg[QB-1];
    assign out_side  = side_reg[QB-1];

endmodule
`default_nettype wire

// ===== rtl/fresnel_reflect_refract_select_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fresnel_reflect_refract_select_top
// Chooses reflection or refraction for one ray hit per item from the
// unpolarized Fresnel reflectance of a dielectric surface.
//
// Each input item carries the cosine, the incident index and a random sample;
// each produces exactly one result item with the choice, the reflectance and
// the total internal reflection and exiting flags. The transmitted index is
// written through the cfg channel, which is always ready. The user must
// write it only while no item is in flight; the block does not enforce it.
// Reset sets the index to 1.5. The path to the output holds two 16-stage
// square roots, a 15-stage and a 17-stage divider and eight glue stages.
// Throughput is one item per cycle unless stalled. The whole pipeline advances
// together: while a result waits on m_tready low, s_tready drops and every
// stage holds, so nothing is lost or repeated. Reset empties the pipeline.
// ----------------------------------------------------------------------------
module fresnel_reflect_refract_select_top
    import frrs_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [15:0] cos_incident, [29:16] eta_incident, [45:30] random_sample
    input  wire logic [47:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [0] reflect_chosen, [17:1] reflectance
    output logic [23:0]      m_tdata,
    // [0] total_internal, [1] exiting
    output logic [1:0]       m_tuser,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [13:0] cfg_data
);

    logic             en;
    logic [ETA_W-1:0] eta_t_reg;

    logic [COS_W-1:0] cos_in;
    logic [COS_W-1:0] c_in;
    logic             a_vld_reg;
    logic [30:0]      a_rad_reg;
    front_side_t      a_side_reg;
    front_side_t      a_side_next;

    logic             s1_vld;
    logic [15:0]      s1_root;
    front_side_t      s1_side;

    logic             b_vld_reg;
    logic [PROD_W-1:0] b_prod_reg;
    front_side_t      b_side_reg;

    logic             t_vld_reg;
    logic [PROD_W-1:0] t_prod_reg;
    mid_side_t        t_side_reg;

    logic             d1_vld;
    logic [SINT_QB-1:0] d1_quot;
    mid_side_t        d1_side;

    logic             m2_vld_reg;
    logic [30:0]      m2_rad_reg;
    mid_side_t        m2_side_reg;

    logic             s2_vld;
    logic [15:0]      s2_root;
    mid_side_t        s2_side;

    logic             m3_vld_reg;
    logic [PROD_W-1:0] m3_a_reg;
    logic [PROD_W-1:0] m3_b_reg;
    logic [PROD_W-1:0] m3_d_reg;
    logic [PROD_W-1:0] m3_e_reg;
    mid_side_t        m3_side_reg;

    logic             n_vld_reg;
    logic [PROD_W-1:0] n_num1_reg;
    logic [PROD_W-1:0] n_num2_reg;
    logic [SUM_W-1:0] n_den1_reg;
    logic [SUM_W-1:0] n_den2_reg;
    tail_side_t       n_side1_reg;
    logic             n_zero2_reg;
    logic [SUM_W-1:0] den1_next;
    logic [SUM_W-1:0] den2_next;

    logic             r1_vld;
    logic [RATIO_QB-1:0] r1_quot;
    tail_side_t       r1_side;
    logic             r2_vld;
    logic [RATIO_QB-1:0] r2_quot;
    logic             r2_zero;

    logic             q_vld_reg;
    logic [KR_W-1:0]  q_sq1_reg;
    logic [KR_W-1:0]  q_sq2_reg;
    tail_side_t       q_side_reg;

    logic [KR_W-1:0]  kr;
    logic             o_vld_reg;
    logic             o_reflect_reg;
    logic [KR_W-1:0]  o_kr_reg;
    logic             o_tir_reg;
    logic             o_exit_reg;

    assign en        = !o_vld_reg || m_tready;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eta_t_reg <= ETA_T_RESET;
        end else if (cfg_valid) begin
            eta_t_reg <= cfg_data;
        end
    end

    assign cos_in = s_tdata[15:0];
    assign c_in   = COS_W'(17'h1_0000 - 17'(cos_in));

    always_comb begin
        a_side_next.exiting = (cos_in != '0) && !cos_in[COS_W-1];
        a_side_next.sample  = s_tdata[45:30];
        a_side_next.eta_i   = s_tdata[29:16];
        a_side_next.c       = c_in;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg  <= 1'b0;
            b_vld_reg  <= 1'b0;
            t_vld_reg  <= 1'b0;
            m2_vld_reg <= 1'b0;
            m3_vld_reg <= 1'b0;
            n_vld_reg  <= 1'b0;
            q_vld_reg  <= 1'b0;
            o_vld_reg  <= 1'b0;
        end else if (en) begin
            a_vld_reg  <= s_tvalid;
            b_vld_reg  <= s1_vld;
            t_vld_reg  <= b_vld_reg;
            m2_vld_reg <= d1_vld;
            m3_vld_reg <= s2_vld;
            n_vld_reg  <= m3_vld_reg;
            q_vld_reg  <= r1_vld && r2_vld;
            o_vld_reg  <= q_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_rad_reg  <= 31'(ONE_Q30 - 32'(c_in) * 32'(c_in));
            a_side_reg <= a_side_next;
        end
    end

    frrs_sqrt_pipe #(
        .ITER (ROOT_ITER),
        .SW   ($bits(front_side_t))
    ) u_sqrt_sin (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (a_vld_reg),
        .in_val    (ROOT_W'(a_rad_reg)),
        .in_side   (a_side_reg),
        .out_valid (s1_vld),
        .out_root  (s1_root),
        .out_side  (s1_side)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            b_prod_reg <= PROD_W'(PROD_W'(s1_side.eta_i) * PROD_W'(s1_root));
            b_side_reg <= s1_side;
            t_prod_reg <= b_prod_reg;
            t_side_reg <= '{exiting: b_side_reg.exiting,
                            tir:     b_prod_reg >= {1'b0, eta_t_reg, 15'b0},
                            sample:  b_side_reg.sample,
                            eta_i:   b_side_reg.eta_i,
                            c:       b_side_reg.c};
        end
    end

    frrs_div_pipe #(
        .NW (PROD_W),
        .DW (ETA_W),
        .QB (SINT_QB),
        .SW ($bits(mid_side_t))
    ) u_div_sint (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (t_vld_reg),
        .in_num    (t_prod_reg),
        .in_den    (eta_t_reg),
        .in_side   (t_side_reg),
        .out_valid (d1_vld),
        .out_quot  (d1_quot),
        .out_side  (d1_side)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            m2_rad_reg  <= d1_side.tir ? '0
                         : 31'(ONE_Q30 - 32'(d1_quot) * 32'(d1_quot));
            m2_side_reg <= d1_side;
        end
    end

    frrs_sqrt_pipe #(
        .ITER (ROOT_ITER),
        .SW   ($bits(mid_side_t))
    ) u_sqrt_cos (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (m2_vld_reg),
        .in_val    (ROOT_W'(m2_rad_reg)),
        .in_side   (m2_side_reg),
        .out_valid (s2_vld),
        .out_root  (s2_root),
        .out_side  (s2_side)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            m3_a_reg    <= PROD_W'(PROD_W'(eta_t_reg) * PROD_W'(s2_side.c));
            m3_b_reg    <= PROD_W'(PROD_W'(s2_side.eta_i) * PROD_W'(s2_root));
            m3_d_reg    <= PROD_W'(PROD_W'(s2_side.eta_i) * PROD_W'(s2_side.c));
            m3_e_reg    <= PROD_W'(PROD_W'(eta_t_reg) * PROD_W'(s2_root));
            m3_side_reg <= s2_side;
        end
    end

    assign den1_next = SUM_W'(m3_a_reg) + SUM_W'(m3_b_reg);
    assign den2_next = SUM_W'(m3_d_reg) + SUM_W'(m3_e_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            n_num1_reg  <= (m3_a_reg >= m3_b_reg) ? m3_a_reg - m3_b_reg
                                                  : m3_b_reg - m3_a_reg;
            n_num2_reg  <= (m3_d_reg >= m3_e_reg) ? m3_d_reg - m3_e_reg
                                                  : m3_e_reg - m3_d_reg;
            n_den1_reg  <= den1_next;
            n_den2_reg  <= den2_next;
            n_side1_reg <= '{exiting:  m3_side_reg.exiting,
                             tir:      m3_side_reg.tir,
                             den_zero: den1_next == '0,
                             sample:   m3_side_reg.sample};
            n_zero2_reg <= den2_next == '0;
        end
    end

    frrs_div_pipe #(
        .NW (RATIO_NW),
        .DW (SUM_W),
        .QB (RATIO_QB),
        .SW ($bits(tail_side_t))
    ) u_div_rs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (n_vld_reg),
        .in_num    ({1'b0, n_num1_reg, 16'b0}),
        .in_den    (n_den1_reg),
        .in_side   (n_side1_reg),
        .out_valid (r1_vld),
        .out_quot  (r1_quot),
        .out_side  (r1_side)
    );

    frrs_div_pipe #(
        .NW (RATIO_NW),
        .DW (SUM_W),
        .QB (RATIO_QB),
        .SW (1)
    ) u_div_rp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (n_vld_reg),
        .in_num    ({1'b0, n_num2_reg, 16'b0}),
        .in_den    (n_den2_reg),
        .in_side   (n_zero2_reg),
        .out_valid (r2_vld),
        .out_quot  (r2_quot),
        .out_side  (r2_zero)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            q_sq1_reg  <= r1_side.den_zero ? ONE_Q16
                        : KR_W'((34'(r1_quot) * 34'(r1_quot)) >> 16);
            q_sq2_reg  <= r2_zero ? ONE_Q16
                        : KR_W'((34'(r2_quot) * 34'(r2_quot)) >> 16);
            q_side_reg <= r1_side;
        end
    end

    assign kr = q_side_reg.tir ? ONE_Q16
              : KR_W'((18'(q_sq1_reg) + 18'(q_sq2_reg)) >> 1);

    always_ff @(posedge aclk) begin
        if (en) begin
            o_exit_reg    <= q_side_reg.exiting;
            o_tir_reg     <= !q_side_reg.exiting && q_side_reg.tir;
            o_kr_reg      <= q_side_reg.exiting ? '0 : kr;
            o_reflect_reg <= !q_side_reg.exiting && (KR_W'(q_side_reg.sample) <= kr);
        end
    end

    assign m_tvalid = o_vld_reg;
    assign m_tdata  = {6'b0, o_kr_reg, o_reflect_reg};
    assign m_tuser  = {o_exit_reg, o_tir_reg};

endmodule
`default_nettype wire
